>>> sv/gcps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcps_pkg
// Types and constants shared by the glyph coverage pixel shader pipeline.
// ----------------------------------------------------------------------------
package gcps_pkg;

	typedef logic [7:0]  alpha_t;
	typedef logic [23:0] color_t;

	// item after neighbour softening or after sharpening
	typedef struct packed {
		alpha_t alpha;
		color_t fore;
		color_t back;
	} shade_t;

	localparam int unsigned CHAN_W       = 8;
	localparam int unsigned NUM_CHAN     = 3;
	localparam int unsigned ALPHA_MAX    = 255;
	localparam int unsigned THRESH_LO    = 24;
	localparam int unsigned THRESH_HI    = 208;
	localparam int unsigned STRETCH_BIAS = 92;
	localparam int unsigned BLEND_ROUND  = 127;

	// x / 184 is done as (x >> 3) / 23, the /23 by reciprocal
	localparam int unsigned STRETCH_PRE_SHIFT = 3;
	localparam int unsigned RECIP_SHIFT       = 17;
	localparam int unsigned RECIP_23          = 5699;
	localparam int unsigned STRETCH_W         = 16;
	localparam int unsigned QUOT_IN_W         = STRETCH_W - STRETCH_PRE_SHIFT;
	localparam int unsigned RECIP_W           = 13;
	localparam int unsigned PROD_W            = QUOT_IN_W + RECIP_W;

	// (a - 24) * 255 + 92 == a * 255 - STRETCH_OFFSET
	localparam int unsigned STRETCH_OFFSET = THRESH_LO * ALPHA_MAX - STRETCH_BIAS;

endpackage

>>> sv/gcps_soften.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcps_soften
// First pipeline stage: neighbour softening, bold fill and underline override.
// ----------------------------------------------------------------------------
module gcps_soften (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      cover_here,
	input  logic [7:0]      cover_left,
	input  logic [7:0]      cover_right,
	input  logic            bold_on,
	input  logic            underline_hit,
	input  logic [23:0]     fore_color,
	input  logic [23:0]     back_color,
	output logic            out_valid,
	input  logic            out_ready,
	output gcps_pkg::shade_t out_data
);
	import gcps_pkg::*;

	logic        valid_s1;
	shade_t      data_s1;
	logic [8:0]  avg_left;
	alpha_t      a_left;
	logic [10:0] pull_right;
	alpha_t      a_right;
	alpha_t      a_final;

	always_comb begin
		avg_left = {1'b0, cover_here} + {1'b0, cover_left} + 9'd1;
		a_left   = (cover_left > cover_here) ? avg_left[8:1] : cover_here;
		// three quarters of the current value plus a quarter of the right one
		pull_right = {2'b00, a_left, 1'b0} + {3'b000, a_left} + {3'b000, cover_right} + 11'd2;
		a_right    = (cover_right > a_left) ? pull_right[9:2] : a_left;
		a_final    = (bold_on && (a_right == '0)) ? cover_left : a_right;
		if (underline_hit) begin
			a_final = alpha_t'(ALPHA_MAX);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.alpha <= a_final;
			data_s1.fore  <= fore_color;
			data_s1.back  <= back_color;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

>>> sv/gcps_sharpen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcps_sharpen
// Threshold and stretch of the coverage over three stages: stretch numerator,
// reciprocal multiply, quotient select.
// ----------------------------------------------------------------------------
module gcps_sharpen (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gcps_pkg::shade_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output gcps_pkg::shade_t out_data
);
	import gcps_pkg::*;

	logic                 valid_s2, valid_s3, valid_s4;
	logic                 ready_s2, ready_s3, ready_s4;
	logic [STRETCH_W-1:0] num_s2;
	logic                 lo_s2, hi_s2, lo_s3, hi_s3;
	color_t               fore_s2, back_s2, fore_s3, back_s3;
	logic [PROD_W-1:0]    prod_s3;
	shade_t               data_s4;
	logic [STRETCH_W-1:0] num_d;
	alpha_t               alpha_d;

	// only meaningful strictly between the thresholds, wraps below the low threshold
	always_comb begin
		num_d = {in_data.alpha, 8'h00} - {8'h00, in_data.alpha}
			- STRETCH_W'(STRETCH_OFFSET);
	end

	always_comb begin
		priority if (lo_s3) begin
			alpha_d = '0;
		end else if (hi_s3) begin
			alpha_d = alpha_t'(ALPHA_MAX);
		end else begin
			alpha_d = prod_s3[RECIP_SHIFT +: CHAN_W];
		end
	end

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			num_s2  <= num_d;
			lo_s2   <= (in_data.alpha <= alpha_t'(THRESH_LO));
			hi_s2   <= (in_data.alpha >= alpha_t'(THRESH_HI));
			fore_s2 <= in_data.fore;
			back_s2 <= in_data.back;
		end
		if (ready_s3 && valid_s2) begin
			prod_s3 <= PROD_W'(num_s2[STRETCH_W-1:STRETCH_PRE_SHIFT])
				* PROD_W'(RECIP_23);
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
			fore_s3 <= fore_s2;
			back_s3 <= back_s2;
		end
		if (ready_s4 && valid_s3) begin
			data_s4.alpha <= alpha_d;
			data_s4.fore  <= fore_s3;
			data_s4.back  <= back_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

>>> sv/gcps_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcps_blend
// Per-channel rounded blend of foreground over background in two stages:
// weighted sum, then divide by 255 and pick the end cases.
// ----------------------------------------------------------------------------
module gcps_blend (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gcps_pkg::shade_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [23:0]      pixel_color
);
	import gcps_pkg::*;

	logic                   valid_s5, valid_s6;
	logic                   ready_s5, ready_s6;
	logic [NUM_CHAN-1:0][15:0] sum_s5;
	logic                   zero_s5, full_s5;
	color_t                 fore_s5, back_s5;
	color_t                 color_s6;
	logic [NUM_CHAN-1:0][15:0] sum_d;
	color_t                 mix_d;
	color_t                 color_d;
	alpha_t                 inv_alpha;
	logic [16:0]            div_tmp;

	always_comb begin
		inv_alpha = alpha_t'(ALPHA_MAX) - in_data.alpha;
		for (int c = 0; c < NUM_CHAN; c++) begin
			sum_d[c] = 16'(in_data.fore[c*CHAN_W +: CHAN_W]) * 16'(in_data.alpha)
				+ 16'(in_data.back[c*CHAN_W +: CHAN_W]) * 16'(inv_alpha)
				+ 16'(BLEND_ROUND);
		end
	end

	// x / 255 as (x + (x >> 8) + 1) >> 8, exact over the sum's range
	always_comb begin
		mix_d   = '0;
		div_tmp = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			div_tmp = {1'b0, sum_s5[c]} + {9'h000, sum_s5[c][15:8]} + 17'd1;
			mix_d[c*CHAN_W +: CHAN_W] = div_tmp[15:8];
		end
		priority if (zero_s5) begin
			color_d = back_s5;
		end else if (full_s5) begin
			color_d = fore_s5;
		end else begin
			color_d = mix_d;
		end
	end

	assign ready_s6 = !valid_s6 || out_ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign in_ready = ready_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s5) begin
				valid_s5 <= in_valid;
			end
			if (ready_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && in_valid) begin
			sum_s5  <= sum_d;
			zero_s5 <= (in_data.alpha == '0);
			full_s5 <= (in_data.alpha == alpha_t'(ALPHA_MAX));
			fore_s5 <= in_data.fore;
			back_s5 <= in_data.back;
		end
		if (ready_s6 && valid_s5) begin
			color_s6 <= color_d;
		end
	end

	assign out_valid   = valid_s6;
	assign pixel_color = color_s6;

endmodule

>>> sv/glyph_coverage_pixel_shader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_coverage_pixel_shader_core
// Antialiased text pixel shader: coverage softening, bold and underline,
// threshold and stretch, and rounded RGB888 blend.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, with no bubbles while the output side keeps
// ready high, and returns its colour from the last register stage. The
// six register stages are softening, stretch numerator, reciprocal multiply,
// quotient select, weighted channel sums and the divide by 255; each stage
// holds its item until the next can take it, so an output stall freezes
// the pipeline back to the input without losing or repeating a transfer.
module glyph_coverage_pixel_shader_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  cover_here,
	input  logic [7:0]  cover_left,
	input  logic [7:0]  cover_right,
	input  logic        bold_on,
	input  logic        underline_hit,
	input  logic [23:0] fore_color,
	input  logic [23:0] back_color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] pixel_color
);
	import gcps_pkg::*;

	logic   soft_valid, soft_ready;
	shade_t soft_data;
	logic   sharp_valid, sharp_ready;
	shade_t sharp_data;

	gcps_soften u_soften (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cover_here    (cover_here),
		.cover_left    (cover_left),
		.cover_right   (cover_right),
		.bold_on       (bold_on),
		.underline_hit (underline_hit),
		.fore_color    (fore_color),
		.back_color    (back_color),
		.out_valid     (soft_valid),
		.out_ready     (soft_ready),
		.out_data      (soft_data)
	);

	gcps_sharpen u_sharpen (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (soft_valid),
		.in_ready  (soft_ready),
		.in_data   (soft_data),
		.out_valid (sharp_valid),
		.out_ready (sharp_ready),
		.out_data  (sharp_data)
	);

	gcps_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sharp_valid),
		.in_ready    (sharp_ready),
		.in_data     (sharp_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_color (pixel_color)
	);

endmodule

>>> tb/pixel_shade_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_shade_checker
// Watches both channels of the text pixel shader. It predicts the shaded
// colour of every pixel taken in and compares it, in order, with every
// colour given out.
// ----------------------------------------------------------------------------
module pixel_shade_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  cover_here,
	input  logic [7:0]  cover_left,
	input  logic [7:0]  cover_right,
	input  logic        bold_on,
	input  logic        underline_hit,
	input  logic [23:0] fore_color,
	input  logic [23:0] back_color,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] pixel_color,
	output int          fail_count,
	output int          pending
);
	import gcps_pkg::*;

	localparam int unsigned STRETCH_DIV = 184;

	color_t      expected_colors[$];
	int unsigned pixels_out;

	initial begin
		fail_count = 0;
		pending    = 0;
		pixels_out = 0;
	end

	task automatic report_error(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	function automatic color_t shade_pixel(
		input alpha_t here,
		input alpha_t left,
		input alpha_t right,
		input logic   bold,
		input logic   under,
		input color_t fore,
		input color_t back
	);
		int unsigned cov;
		int          ch;
		color_t      mixed;
		cov = here;
		// soften toward stronger neighbours
		if (left > cov) begin
			cov = (cov + left + 1) / 2;
		end
		if (right > cov) begin
			cov = (cov * 3 + right + 2) / 4;
		end
		if (bold && cov == 0) begin
			cov = left;
		end
		if (under) begin
			cov = ALPHA_MAX;
		end
		if (cov <= THRESH_LO) begin
			cov = 0;
		end else if (cov >= THRESH_HI) begin
			cov = ALPHA_MAX;
		end else begin
			cov = ((cov - THRESH_LO) * ALPHA_MAX + STRETCH_BIAS) / STRETCH_DIV;
		end
		if (cov == 0) begin
			return back;
		end
		if (cov == ALPHA_MAX) begin
			return fore;
		end
		for (ch = 0; ch < NUM_CHAN; ch++) begin
			mixed[ch*CHAN_W +: CHAN_W] = CHAN_W'((int'(fore[ch*CHAN_W +: CHAN_W]) * cov
				+ int'(back[ch*CHAN_W +: CHAN_W]) * (ALPHA_MAX - cov)
				+ BLEND_ROUND) / ALPHA_MAX);
		end
		return mixed;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_colors.push_back(shade_pixel(cover_here, cover_left, cover_right,
					bold_on, underline_hit, fore_color, back_color));
			end
			if (out_valid && out_ready) begin
				if (expected_colors.size() == 0) begin
					report_error($sformatf("pixel_color %06h with no pixel outstanding",
						pixel_color));
				end else begin
					if (pixel_color !== expected_colors[0]) begin
						report_error($sformatf("pixel %0d: pixel_color %06h, expected %06h",
							pixels_out, pixel_color, expected_colors[0]));
					end
					void'(expected_colors.pop_front());
				end
				pixels_out++;
			end
			pending <= expected_colors.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the text pixel shader: directed corner pixels, then random
// pixels with random idle cycles on both sides. The checker does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

	import gcps_pkg::*;

	localparam int RANDOM_PIXELS = 800;
	localparam int DRAIN_CYCLES  = 24;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [7:0]  cover_here    = '0;
	logic [7:0]  cover_left    = '0;
	logic [7:0]  cover_right   = '0;
	logic        bold_on       = 1'b0;
	logic        underline_hit = 1'b0;
	logic [23:0] fore_color    = '0;
	logic [23:0] back_color    = '0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [23:0] pixel_color;

	// no idle cycles on either side while set
	logic calm = 1'b0;
	int   fail_count;
	int   pending;

	glyph_coverage_pixel_shader_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cover_here    (cover_here),
		.cover_left    (cover_left),
		.cover_right   (cover_right),
		.bold_on       (bold_on),
		.underline_hit (underline_hit),
		.fore_color    (fore_color),
		.back_color    (back_color),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_color   (pixel_color)
	);

	pixel_shade_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cover_here    (cover_here),
		.cover_left    (cover_left),
		.cover_right   (cover_right),
		.bold_on       (bold_on),
		.underline_hit (underline_hit),
		.fore_color    (fore_color),
		.back_color    (back_color),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_color   (pixel_color),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 32);
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic send_pixel(
		input alpha_t here,
		input alpha_t left,
		input alpha_t right,
		input logic   bold,
		input logic   under,
		input color_t fore,
		input color_t back
	);
		if (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 32);
		end
		in_valid      <= 1'b1;
		cover_here    <= here;
		cover_left    <= left;
		cover_right   <= right;
		bold_on       <= bold;
		underline_hit <= under;
		fore_color    <= fore;
		back_color    <= back;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic alpha_t pick_cover();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			2: return alpha_t'($urandom_range(20, 30));
			3: return alpha_t'($urandom_range(200, 215));
			default: return alpha_t'($urandom_range(255));
		endcase
	endfunction

	function automatic color_t pick_color();
		case ($urandom_range(7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return color_t'($urandom);
		endcase
	endfunction

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ends of the blend, threshold edges
		send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 24'hFFFFFF, 24'h000000);
		send_pixel(8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 24'hFFFFFF, 24'h000000);
		send_pixel(8'd24,  8'd0,   8'd0,   1'b0, 1'b0, 24'h123456, 24'hABCDEF);
		send_pixel(8'd25,  8'd0,   8'd0,   1'b0, 1'b0, 24'hFFFFFF, 24'h000000);
		send_pixel(8'd207, 8'd0,   8'd0,   1'b0, 1'b0, 24'hFFFFFF, 24'h000000);
		send_pixel(8'd208, 8'd0,   8'd0,   1'b0, 1'b0, 24'h00FF00, 24'hFF00FF);
		send_pixel(8'd1,   8'd0,   8'd0,   1'b0, 1'b0, 24'hFFFFFF, 24'hFFFFFF);
		// bold at the first column stays empty
		send_pixel(8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 24'hFFFFFF, 24'h202020);
		send_pixel(8'd0,   8'd1,   8'd0,   1'b1, 1'b0, 24'hFFFFFF, 24'h202020);
		send_pixel(8'd0,   8'd200, 8'd0,   1'b1, 1'b0, 24'hFFFFFF, 24'h000000);
		// stronger left, stronger right, both
		send_pixel(8'd100, 8'd200, 8'd0,   1'b0, 1'b0, 24'hFF8000, 24'h0080FF);
		send_pixel(8'd100, 8'd0,   8'd200, 1'b0, 1'b0, 24'hFF8000, 24'h0080FF);
		send_pixel(8'd100, 8'd200, 8'd255, 1'b0, 1'b0, 24'hFFFFFF, 24'h000000);
		send_pixel(8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 24'h808080, 24'h7F7F7F);
		send_pixel(8'd24,  8'd25,  8'd0,   1'b0, 1'b0, 24'hFFFFFF, 24'h000000);
		send_pixel(8'd0,   8'd0,   8'd100, 1'b0, 1'b0, 24'hFFFFFF, 24'h000000);
		// underline row forces the foreground
		send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 24'hC0FFEE, 24'h000000);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 24'h000000, 24'hFFFFFF);
		send_pixel(8'd128, 8'd0,   8'd0,   1'b0, 1'b0, 24'hFF00FF, 24'h00FF00);
		send_pixel(8'd116, 8'd50,  8'd150, 1'b1, 1'b0, 24'h13579B, 24'hFDB975);
		send_pixel(8'd160, 8'd255, 8'd0,   1'b0, 1'b0, 24'hFFFFFF, 24'h000000);

		for (n = 0; n < RANDOM_PIXELS; n++) begin
			calm <= (n >= 300 && n < 450);
			send_pixel(pick_cover(), pick_cover(), pick_cover(), 1'($urandom_range(1)),
				$urandom_range(7) == 0, pick_color(), pick_color());
		end
		in_valid <= 1'b0;
		calm     <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/gcps_pkg.sv
sv/gcps_soften.sv
sv/gcps_sharpen.sv
sv/gcps_blend.sv
sv/glyph_coverage_pixel_shader_core.sv
tb/pixel_shade_checker.sv
tb/testbench.sv
